/* rtl/core/lfmp_pkg.sv */
package lfmp_pkg;

  // PWM period in ticks
  localparam logic [6:0] PWM_PERIOD = 7'd100;

  // Register reset values
  localparam logic [6:0]  TURN_RED_RST    = 7'd20;
  localparam logic [6:0]  SHARP_DUTY_RST  = 7'd3;
  localparam logic [15:0] PAUSE_TICKS_RST = 16'd48000;

  // Speed presets selected by key
  localparam logic [6:0] SPEED_40  = 7'd40;
  localparam logic [6:0] SPEED_50  = 7'd50;
  localparam logic [6:0] SPEED_70  = 7'd70;
  localparam logic [6:0] SPEED_90  = 7'd90;
  localparam logic [6:0] SPEED_100 = 7'd100;

  // Station sensors all high means no station seen
  localparam logic [2:0] STATION_NONE = 3'b111;

  // Active-low line nibble patterns
  localparam logic [3:0] PAT_DARK = 4'h0;
  localparam logic [3:0] PAT_D    = 4'hd;
  localparam logic [3:0] PAT_C    = 4'hc;
  localparam logic [3:0] PAT_E    = 4'he;
  localparam logic [3:0] PAT_B    = 4'hb;
  localparam logic [3:0] PAT_7    = 4'h7;
  localparam logic [3:0] PAT_3    = 4'h3;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_REV  = 2'd2
  } mode_e;

  // Which wheel is the inner one, and how hard it is slowed
  typedef enum logic [2:0] {
    TURN_STRAIGHT = 3'd0,
    TURN_GENTLE_L = 3'd1,
    TURN_SHARP_L  = 3'd2,
    TURN_GENTLE_R = 3'd3,
    TURN_SHARP_R  = 3'd4
  } turn_e;

  typedef enum logic [3:0] {
    KEY_NONE     = 4'd0,
    KEY_SPEED40  = 4'd1,
    KEY_REVERSE  = 4'd2,
    KEY_FORWARD  = 4'd3,
    KEY_STOP     = 4'd4,
    KEY_SPEED100 = 4'd5,
    KEY_SPEED90  = 4'd6,
    KEY_SPEED70  = 4'd7,
    KEY_SPEED50  = 4'd8
  } key_e;

  typedef enum logic [1:0] {
    CFG_TURN_RED    = 2'd0,
    CFG_SHARP_DUTY  = 2'd1,
    CFG_PAUSE_TICKS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic       obstacle_n;
    logic [7:0] line_sensors;
    logic [2:0] stop_sensors;
    logic [3:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic       enable;
    logic       left_pwm;
    logic       right_pwm;
    logic       left_dir;
    logic       right_dir;
    logic [1:0] mode_now;
  } out_item_t;

  // Map a non-dark line nibble to a turn kind; reverse mirrors the wheels
  function automatic turn_e decode_turn(input logic [3:0] nib, input logic fwd);
    turn_e k;
    k = TURN_STRAIGHT;
    case (nib)
      PAT_D:        k = fwd ? TURN_GENTLE_L : TURN_GENTLE_R;
      PAT_C, PAT_E: k = fwd ? TURN_SHARP_L  : TURN_SHARP_R;
      PAT_B:        k = fwd ? TURN_GENTLE_R : TURN_GENTLE_L;
      PAT_7, PAT_3: k = fwd ? TURN_SHARP_R  : TURN_SHARP_L;
      default:      k = TURN_STRAIGHT;
    endcase
    return k;
  endfunction

endpackage

/* rtl/core/line_follower_motor_pwm.sv */
// Channel | Signals                          | Direction
// --------+----------------------------------+----------
// in      | in_valid_i, in_ready_o, in_data_i    | input item, one per PWM tick
// out     | out_valid_o, out_ready_i, out_data_o | result, one per input item
// cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | register write
//
// One tick per cycle while the result register can take it: an accepted item
// updates the state registers and lands in the result register on the same edge.
// The input is taken whenever the result register is empty or being drained,
// so a stall on the output only blocks the input while the result waits.
// Reset clears the mode, pause and phase state and loads register defaults.
// Configuration writes are always taken (cfg_ready_o is tied high).
module line_follower_motor_pwm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lfmp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lfmp_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import lfmp_pkg::*;

  logic [6:0]  turn_red_q, sharp_duty_q;
  logic [15:0] pause_ticks_q;

  mode_e       mode_q, mode_d;
  mode_e       saved_q, saved_d;
  turn_e       turn_q, turn_d;
  logic [6:0]  speed_q, speed_d;
  logic [6:0]  phase_q, phase_d;
  logic        held_q, held_d;
  logic        pact_q, pact_d;
  logic [15:0] pcnt_q, pcnt_d;
  logic [3:0]  drive_q, drive_d;

  logic        out_valid_q;
  out_item_t   out_q, out_d;

  logic        in_xfer;
  logic [3:0]  nib;
  logic [6:0]  phase_inc;
  logic [6:0]  gentle_duty;
  logic        full_on, gentle_on, sharp_on, l_on, r_on;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Tick logic: obstacle, key, line, stations, pause, drive
  always_comb begin
    mode_d  = mode_q;
    saved_d = saved_q;
    turn_d  = turn_q;
    speed_d = speed_q;
    held_d  = held_q;
    pact_d  = pact_q;
    pcnt_d  = pcnt_q;
    drive_d = drive_q;

    // Obstacle pause: save and stop on arrival, arm pause on release
    if (!in_data_i.obstacle_n) begin
      if (!held_q) begin
        saved_d = mode_q;
        mode_d  = MODE_STOP;
        held_d  = 1'b1;
      end
    end else if (held_q) begin
      held_d = 1'b0;
      pact_d = 1'b1;
    end

    // Key: speed presets and mode changes; unknown codes ignored
    case (in_data_i.key_code)
      KEY_SPEED40:  speed_d = SPEED_40;
      KEY_REVERSE:  begin mode_d = MODE_REV; saved_d = MODE_REV; end
      KEY_FORWARD:  begin mode_d = MODE_FWD; saved_d = MODE_FWD; end
      KEY_STOP:     mode_d = MODE_STOP;
      KEY_SPEED100: speed_d = SPEED_100;
      KEY_SPEED90:  speed_d = SPEED_90;
      KEY_SPEED70:  speed_d = SPEED_70;
      KEY_SPEED50:  speed_d = SPEED_50;
      default:      ;
    endcase

    // Line decode: dark nibble stops, otherwise pick the turn kind
    nib = (mode_d == MODE_FWD) ? in_data_i.line_sensors[3:0]
                               : in_data_i.line_sensors[7:4];
    if (mode_d inside {MODE_FWD, MODE_REV}) begin
      if (nib == PAT_DARK) mode_d = MODE_STOP;
      else turn_d = decode_turn(nib, mode_d == MODE_FWD);
    end

    // Any station sensor low stops the car
    if (in_data_i.stop_sensors != STATION_NONE) mode_d = MODE_STOP;

    // Advance phase, count up the pause
    phase_inc = 7'(phase_q + 7'd1);
    if (pact_d) begin
      pcnt_d = 16'(pcnt_q + 16'd1);
      if (pcnt_d >= pause_ticks_q) begin
        pact_d = 1'b0;
        pcnt_d = '0;
        mode_d = saved_d;
      end
    end

    // Duty compares; gentle duty saturates at zero
    gentle_duty = (speed_d > turn_red_q) ? 7'(speed_d - turn_red_q) : 7'd0;
    full_on     = phase_inc < speed_d;
    gentle_on   = phase_inc < gentle_duty;
    sharp_on    = phase_inc < sharp_duty_q;
    l_on = full_on;
    r_on = full_on;
    case (turn_d)
      TURN_GENTLE_L: l_on = gentle_on;
      TURN_SHARP_L:  l_on = sharp_on;
      TURN_GENTLE_R: r_on = gentle_on;
      TURN_SHARP_R:  r_on = sharp_on;
      default:       ;
    endcase

    // Drive bits: forward on pwm bits, reverse on dir bits, hold in stop
    case (mode_d)
      MODE_FWD: drive_d = {2'b00, r_on, l_on};
      MODE_REV: drive_d = {r_on, l_on, 2'b00};
      default:  ;
    endcase

    phase_d = (phase_inc >= PWM_PERIOD) ? 7'd0 : phase_inc;

    out_d.enable    = mode_d inside {MODE_FWD, MODE_REV};
    out_d.left_pwm  = drive_d[0];
    out_d.right_pwm = drive_d[1];
    out_d.left_dir  = drive_d[2];
    out_d.right_dir = drive_d[3];
    out_d.mode_now  = mode_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_red_q    <= TURN_RED_RST;
      sharp_duty_q  <= SHARP_DUTY_RST;
      pause_ticks_q <= PAUSE_TICKS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TURN_RED:    turn_red_q    <= cfg_data_i[6:0];
        CFG_SHARP_DUTY:  sharp_duty_q  <= cfg_data_i[6:0];
        CFG_PAUSE_TICKS: pause_ticks_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // State update on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_STOP;
      saved_q <= MODE_STOP;
      turn_q  <= TURN_STRAIGHT;
      speed_q <= '0;
      phase_q <= '0;
      held_q  <= 1'b0;
      pact_q  <= 1'b0;
      pcnt_q  <= '0;
      drive_q <= '0;
    end else if (in_xfer) begin
      mode_q  <= mode_d;
      saved_q <= saved_d;
      turn_q  <= turn_d;
      speed_q <= speed_d;
      phase_q <= phase_d;
      held_q  <= held_d;
      pact_q  <= pact_d;
      pcnt_q  <= pcnt_d;
      drive_q <= drive_d;
    end
  end

  // Result register: load on input transfer, drop on output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) out_q <= out_d;
  end

`ifndef ASSERT_OFF
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < PWM_PERIOD)
    else $error("phase counter out of range");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("no result after input transfer");

  a_enable_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.enable == (out_data_o.mode_now != MODE_STOP)))
    else $error("enable disagrees with mode");

  a_pause_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !pact_d) |=> (pcnt_q == $past(pcnt_q)) || (pcnt_q == 16'd0))
    else $error("pause counter moved while idle");
`endif

endmodule
